/* hdl/gqls_pkg.sv */
package gqls_pkg;

   localparam int Q_W = 24;
   localparam int SUM_W = 27;
   localparam int CNT_W = 6;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int MAX_SHADOW_SIZE = 4;
   localparam logic [20:0] NEWLINE_CODE = 21'd10;

   localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(8388608);

   typedef enum logic [2:0] {
      REG_LINE_HEIGHT   = 3'd0,
      REG_MAX_WIDTH     = 3'd1,
      REG_SHADOW_SIZE   = 3'd2,
      REG_SHADOW_OFFS_X = 3'd3,
      REG_SHADOW_OFFS_Y = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic        [15:0] line_height;
      logic        [19:0] max_width;
      logic        [2:0]  shadow_size;
      logic signed [11:0] shadow_offset_x;
      logic signed [11:0] shadow_offset_y;
   } cfg_type;

   typedef struct packed {
      logic signed [Q_W-1:0] bottom_y;
      logic signed [Q_W-1:0] right_x;
      logic signed [Q_W-1:0] top_y;
      logic signed [Q_W-1:0] left_x;
   } quad_type;

   function automatic logic signed [Q_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[Q_W-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hdl/glyph_quad_layout_with_shadow.sv */
// Glyph quad layout with shadow copies.
// req channel: one beat per character, code plus font metrics. new_text puts
// the pen at the origin first; code 10 is a newline.
// rsp channel: per character, the shadow copies in scan order (tuser = 1),
// then the main quad with tlast = 1. Coordinates are Q20.4 and saturate.
// csr channel: register writes, always ready; write only while idle.
// On an idle block an accepted req beat is written into the quad queue and
// then into the output register that drives rsp_tvalid.
// Throughput: the front takes one character a cycle while the four-entry
// quad queue has room. The back produces one rsp beat a cycle while a quad
// waits and the receiver takes beats; a character gives n shadow beats and
// one main beat (n = 0 with shadows off; 1, 4, 16 or 36 for spread 1 to 4).
// When the receiver stalls, the output register holds its beat, the back
// stops, the queue fills and req_tready drops once it is full.
// Reset (synchronous, high) zeroes the pen, the registers and the output
// valid and empties the queue; no clearing pass is needed.
module glyph_quad_layout_with_shadow (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // new_text, char_code[20:0], glyph_present, advance[15:0], glyph_width[15:0],
   // glyph_height[15:0], bearing_x[15:0], bearing_y[15:0], zero pad
   input  logic [103:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // left_x[23:0], top_y[23:0], right_x[23:0], bottom_y[23:0], copy_number[5:0],
   // zero pad
   output logic [103:0]  rsp_tdata,
   // is_shadow
   output logic          rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [19:0]   csr_data
);

   gqls_pkg::cfg_type            cfg_ff;
   logic                         q_push, q_pop, q_full, q_empty;
   gqls_pkg::quad_type           front_quad, head_quad, out_quad;
   logic [gqls_pkg::CNT_W-1:0]   out_copy;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (gqls_pkg::reg_index_type'(csr_index))
            gqls_pkg::REG_LINE_HEIGHT:   cfg_ff.line_height     <= csr_data[15:0];
            gqls_pkg::REG_MAX_WIDTH:     cfg_ff.max_width       <= csr_data;
            gqls_pkg::REG_SHADOW_SIZE:   cfg_ff.shadow_size     <= csr_data[2:0];
            gqls_pkg::REG_SHADOW_OFFS_X: cfg_ff.shadow_offset_x <= csr_data[11:0];
            gqls_pkg::REG_SHADOW_OFFS_Y: cfg_ff.shadow_offset_y <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   gqls_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .take          (q_push),
      .new_text      (req_tdata[0]),
      .char_code     (req_tdata[21:1]),
      .glyph_present (req_tdata[22]),
      .advance       (req_tdata[38:23]),
      .glyph_width   (req_tdata[54:39]),
      .glyph_height  (req_tdata[70:55]),
      .bearing_x     (req_tdata[86:71]),
      .bearing_y     (req_tdata[102:87]),
      .quad          (front_quad)
   );

   gqls_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .pop     (q_pop),
      .wr_quad (front_quad),
      .rd_quad (head_quad),
      .full    (q_full),
      .empty   (q_empty)
   );

   gqls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head_quad),
      .head_valid (!q_empty),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_quad   (out_quad),
      .out_copy   (out_copy),
      .out_shadow (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_copy, out_quad};

   a_last_not_shadow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast != rsp_tuser))
      else $error("main quad flag and shadow flag disagree");

   a_no_shadow_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && cfg_ff.shadow_size == 3'd0) |-> (rsp_tlast && out_copy == '0))
      else $error("shadow beat with shadows off");

   a_copy_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (out_copy < 6'd36))
      else $error("shadow copy number out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

endmodule

/* hdl/gqls_front.sv */
module gqls_front (
   input  logic                 clock,
   input  logic                 reset,
   input  gqls_pkg::cfg_type    cfg,
   input  logic                 take,
   input  logic                 new_text,
   input  logic [20:0]          char_code,
   input  logic                 glyph_present,
   input  logic [15:0]          advance,
   input  logic [15:0]          glyph_width,
   input  logic [15:0]          glyph_height,
   input  logic signed [15:0]   bearing_x,
   input  logic signed [15:0]   bearing_y,
   output gqls_pkg::quad_type   quad
);

   logic signed [gqls_pkg::Q_W-1:0] pen_x_ff, pen_x_in;
   logic signed [gqls_pkg::Q_W-1:0] pen_y_ff, pen_y_in;

   logic signed [gqls_pkg::Q_W-1:0]   px, py;
   logic signed [gqls_pkg::SUM_W-1:0] px_adv, py_lh, bx_e, by_e, gw_e, gh_e;
   logic                              wrap;

   always_comb begin
      px = new_text ? '0 : pen_x_ff;
      py = new_text ? '0 : pen_y_ff;
      bx_e = gqls_pkg::SUM_W'(bearing_x);
      by_e = gqls_pkg::SUM_W'(bearing_y);
      gw_e = gqls_pkg::SUM_W'({1'b0, glyph_width});
      gh_e = gqls_pkg::SUM_W'({1'b0, glyph_height});
      px_adv = gqls_pkg::SUM_W'(px) + gqls_pkg::SUM_W'({1'b0, advance});
      py_lh = gqls_pkg::SUM_W'(py) + gqls_pkg::SUM_W'({1'b0, cfg.line_height});
      wrap = (cfg.max_width != '0) && (px != '0) &&
             (px_adv >= gqls_pkg::SUM_W'({1'b0, cfg.max_width}));
      quad = '0;
      pen_x_in = px;
      pen_y_in = py;
      if (char_code == gqls_pkg::NEWLINE_CODE) begin
         pen_x_in = '0;
         pen_y_in = gqls_pkg::sat24(py_lh);
      end else if (glyph_present) begin
         if (wrap) begin
            px = '0;
            py = gqls_pkg::sat24(py_lh);
            px_adv = gqls_pkg::SUM_W'({1'b0, advance});
         end
         quad.left_x   = gqls_pkg::sat24(gqls_pkg::SUM_W'(px) + bx_e);
         quad.top_y    = gqls_pkg::sat24(gqls_pkg::SUM_W'(py) + by_e);
         quad.right_x  = gqls_pkg::sat24(gqls_pkg::SUM_W'(px) + bx_e + gw_e);
         quad.bottom_y = gqls_pkg::sat24(gqls_pkg::SUM_W'(py) + by_e + gh_e);
         pen_x_in = gqls_pkg::sat24(px_adv);
         pen_y_in = py;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
      end else if (take) begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
      end
   end

endmodule

/* hdl/gqls_fifo.sv */
module gqls_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               pop,
   input  gqls_pkg::quad_type wr_quad,
   output gqls_pkg::quad_type rd_quad,
   output logic               full,
   output logic               empty
);

   gqls_pkg::quad_type               mem_ff [gqls_pkg::FIFO_DEPTH];
   logic [gqls_pkg::PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [gqls_pkg::PTR_W:0]         count_ff, count_in;

   assign full    = (count_ff == (gqls_pkg::PTR_W+1)'(gqls_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_quad = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_quad;
      end
   end

endmodule

/* hdl/gqls_back.sv */
module gqls_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gqls_pkg::cfg_type             cfg,
   input  gqls_pkg::quad_type            head,
   input  logic                          head_valid,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output gqls_pkg::quad_type            out_quad,
   output logic [gqls_pkg::CNT_W-1:0]    out_copy,
   output logic                          out_shadow,
   output logic                          out_last
);

   logic                         valid_ff;
   gqls_pkg::quad_type           quad_ff, quad_in;
   logic [gqls_pkg::CNT_W-1:0]   copy_ff, copy_in;
   logic                         shadow_ff, shadow_in, last_ff, last_in;
   logic [gqls_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [3:0]            sx_ff, sy_ff, sx_in, sy_in;

   logic [2:0]                   s;
   logic signed [3:0]            lim, cur_sx, cur_sy, nx, ny;
   logic [gqls_pkg::CNT_W-1:0]   total;
   logic                         emit_main, step;
   logic signed [16:0]           dx, dy;

   function automatic logic [3:0] mag(input logic signed [3:0] v);
      return (v < 0) ? 4'(-v) : 4'(v);
   endfunction

   function automatic logic diag(input logic signed [3:0] x, input logic signed [3:0] y,
                                 input logic [2:0] sz);
      return (sz != 3'd1) && (mag(x) == mag(y));
   endfunction

   // scan order: x inner, y outer
   function automatic logic [7:0] raw_step(input logic signed [3:0] x,
                                           input logic signed [3:0] y,
                                           input logic signed [3:0] l);
      logic [7:0] r;
      if (x == l) begin
         r = {4'(-l), 4'(y + 4'sd1)};
      end else begin
         r = {4'(x + 4'sd1), y};
      end
      return r;
   endfunction

   assign out_valid  = valid_ff;
   assign out_quad   = quad_ff;
   assign out_copy   = copy_ff;
   assign out_shadow = shadow_ff;
   assign out_last   = last_ff;

   always_comb begin
      logic [7:0] c;
      s = (cfg.shadow_size > 3'(gqls_pkg::MAX_SHADOW_SIZE)) ?
          3'(gqls_pkg::MAX_SHADOW_SIZE) : cfg.shadow_size;
      lim = 4'(s) - 4'sd1;
      if (s <= 3'd1) begin
         total = gqls_pkg::CNT_W'(s);
      end else begin
         total = gqls_pkg::CNT_W'((2 * s - 1) * (2 * s - 1) - (4 * s - 3));
      end
      // first cell of the first row skips the corner
      if (cnt_ff == '0) begin
         cur_sx = (s == 3'd1) ? 4'sd0 : 4'(-(lim - 4'sd1));
         cur_sy = (s == 3'd1) ? 4'sd0 : 4'(-lim);
      end else begin
         cur_sx = sx_ff;
         cur_sy = sy_ff;
      end
      c = raw_step(cur_sx, cur_sy, lim);
      if (diag(c[7:4], c[3:0], s)) begin
         c = raw_step(c[7:4], c[3:0], lim);
      end
      if (diag(c[7:4], c[3:0], s)) begin
         c = raw_step(c[7:4], c[3:0], lim);
      end
      nx = c[7:4];
      ny = c[3:0];

      dx = 17'((18'(cfg.shadow_offset_x) + 18'(cur_sx)) <<< 4);
      dy = 17'((18'(cfg.shadow_offset_y) + 18'(cur_sy)) <<< 4);

      emit_main = (s == 3'd0) || (cnt_ff == total);
      step = head_valid && (!valid_ff || out_ready);
      pop = step && emit_main;

      quad_in   = head;
      copy_in   = cnt_ff;
      shadow_in = !emit_main;
      last_in   = emit_main;
      cnt_in    = cnt_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      if (!emit_main) begin
         quad_in.left_x   = gqls_pkg::sat24(gqls_pkg::SUM_W'(head.left_x) +
                                            gqls_pkg::SUM_W'(dx));
         quad_in.right_x  = gqls_pkg::sat24(gqls_pkg::SUM_W'(head.right_x) +
                                            gqls_pkg::SUM_W'(dx));
         quad_in.top_y    = gqls_pkg::sat24(gqls_pkg::SUM_W'(head.top_y) +
                                            gqls_pkg::SUM_W'(dy));
         quad_in.bottom_y = gqls_pkg::sat24(gqls_pkg::SUM_W'(head.bottom_y) +
                                            gqls_pkg::SUM_W'(dy));
      end
      if (step) begin
         if (emit_main) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            sx_in  = nx;
            sy_in  = ny;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (step) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      if (step) begin
         quad_ff   <= quad_in;
         copy_ff   <= copy_in;
         shadow_ff <= shadow_in;
         last_ff   <= last_in;
      end
   end

endmodule
